// ===== hdl/wrh_pkg.sv =====
// shared constants, types and helper functions of the weighted rgb histogram
package wrh_pkg;

   localparam int MAX_BPC_DEFAULT = 4;
   localparam int ACCUM_W_DEFAULT = 48;

   localparam int OPCODE_W = 2;
   localparam int CHAN_W   = 18;
   localparam int WEIGHT_W = 16;
   localparam int SEL_W    = 12;
   localparam int OUT_W    = 48;
   localparam int CENTER_W = 16;
   localparam int CLAMP_W  = 16;
   localparam int BPC_W    = 3;

   localparam logic [BPC_W-1:0]    BPC_RESET   = 3'd4;
   localparam logic [CLAMP_W-1:0]  CHANNEL_MAX = 16'd65470;

   localparam logic [OPCODE_W-1:0] OP_ACCUM = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic accept;
      logic write_back;
      logic load_rsp;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic rsp_hold;
      logic clear_last;
   } status_type;

   // negative goes to zero, large values to the 0.999 limit
   function automatic logic [CLAMP_W-1:0] clamp_channel(input logic signed [CHAN_W-1:0] v);
      logic [CLAMP_W-1:0] res;
      begin
         if (v[CHAN_W-1]) begin
            res = '0;
         end else if (v[CHAN_W-2:0] > (CHAN_W-1)'(CHANNEL_MAX)) begin
            res = CHANNEL_MAX;
         end else begin
            res = v[CLAMP_W-1:0];
         end
         return res;
      end
   endfunction

   // (2c+1) << (15-bpc), low 16 bits
   function automatic logic [CENTER_W-1:0] center_of(input logic [CENTER_W-1:0] code,
                                                    input logic [BPC_W-1:0] bpc);
      logic [2*CENTER_W-1:0] t;
      begin
         t = {15'd0, code, 1'b1} << (5'd15 - 5'(bpc));
         return t[CENTER_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/wrh_ctrl.sv =====
// control state machine of the weighted rgb histogram
module wrh_ctrl import wrh_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                req_stall,
   input  status_type          status,
   output cmd_type             cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ACCUM = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_CLEAR = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (req_opcode)
                  OP_ACCUM: state_in = ST_ACCUM;
                  OP_READ:  state_in = ST_READ;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACCUM: begin
            cmd.write_back = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_READ: begin
            if (!status.rsp_hold) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== hdl/wrh_datapath.sv =====
// bin store, index and centre arithmetic, configuration and result registers
module wrh_datapath import wrh_pkg::*; #(
   parameter int MAX_BPC = MAX_BPC_DEFAULT,
   parameter int ACCUM_W = ACCUM_W_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [BPC_W-1:0]           csr_bits_per_channel,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [CHAN_W-1:0]   req_red_value,
   input  logic signed [CHAN_W-1:0]   req_green_value,
   input  logic signed [CHAN_W-1:0]   req_blue_value,
   input  logic [WEIGHT_W-1:0]        req_sample_weight,
   input  logic [SEL_W-1:0]           req_bin_select,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [OUT_W-1:0]           rsp_bin_weight,
   output logic [CENTER_W-1:0]        rsp_center_red,
   output logic [CENTER_W-1:0]        rsp_center_green,
   output logic [CENTER_W-1:0]        rsp_center_blue,
   input  cmd_type                    cmd,
   output status_type                 status
);

   localparam int IDX_W = 3 * MAX_BPC;
   localparam int DEPTH = 1 << IDX_W;

   logic [ACCUM_W-1:0] mem [DEPTH];

   logic [BPC_W-1:0]    bpc_ff;
   logic [BPC_W-1:0]    eff_bpc;
   logic [4:0]          sub_shift;
   logic [4:0]          sh2;
   logic [4:0]          sh3;
   logic [IDX_W-1:0]    bin_mask;
   logic [MAX_BPC-1:0]  chan_mask;
   logic [CLAMP_W-1:0]  sr_full;
   logic [CLAMP_W-1:0]  sg_full;
   logic [CLAMP_W-1:0]  sb_full;
   logic [IDX_W-1:0]    acc_idx;
   logic [IDX_W+SEL_W-1:0] sel_ext;
   logic [IDX_W-1:0]    sel_idx;
   logic [IDX_W-1:0]    addr_in;
   logic [IDX_W-1:0]    idx_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [ACCUM_W-1:0]  rdata_ff;
   logic [ACCUM_W:0]    sum_wide;
   logic [ACCUM_W-1:0]  sum_sat;
   logic [IDX_W-1:0]    clr_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [ACCUM_W-1:0]  mem_wdata;
   logic [IDX_W-1:0]    code_r_full;
   logic [IDX_W-1:0]    code_g_full;
   logic [MAX_BPC-1:0]  code_r;
   logic [MAX_BPC-1:0]  code_g;
   logic [MAX_BPC-1:0]  code_b;
   logic [ACCUM_W+OUT_W-1:0] weight_ext;

   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    rsp_weight_ff;
   logic [CENTER_W-1:0] rsp_red_ff;
   logic [CENTER_W-1:0] rsp_green_ff;
   logic [CENTER_W-1:0] rsp_blue_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpc_ff <= BPC_RESET;
      end else if (csr_valid && csr_ready) begin
         bpc_ff <= csr_bits_per_channel;
      end
   end

   always_comb begin
      if (bpc_ff == '0) begin
         eff_bpc = BPC_W'(1);
      end else if (bpc_ff > BPC_W'(MAX_BPC)) begin
         eff_bpc = BPC_W'(MAX_BPC);
      end else begin
         eff_bpc = bpc_ff;
      end
   end

   assign sub_shift = 5'(CLAMP_W) - 5'(eff_bpc);
   assign sh2       = {1'b0, eff_bpc, 1'b0};
   assign sh3       = sh2 + 5'(eff_bpc);
   assign bin_mask  = ~({IDX_W{1'b1}} << sh3);
   assign chan_mask = ~({MAX_BPC{1'b1}} << eff_bpc);

   assign sr_full = clamp_channel(req_red_value) >> sub_shift;
   assign sg_full = clamp_channel(req_green_value) >> sub_shift;
   assign sb_full = clamp_channel(req_blue_value) >> sub_shift;

   assign acc_idx = ((IDX_W'(sr_full[MAX_BPC-1:0]) << sh2)
                    | (IDX_W'(sg_full[MAX_BPC-1:0]) << eff_bpc)
                    | IDX_W'(sb_full[MAX_BPC-1:0])) & bin_mask;

   assign sel_ext = (IDX_W+SEL_W)'(req_bin_select);
   assign sel_idx = sel_ext[IDX_W-1:0] & bin_mask;
   assign addr_in = (req_opcode == OP_READ) ? sel_idx : acc_idx;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         idx_ff    <= addr_in;
         weight_ff <= req_sample_weight;
         rdata_ff  <= mem[addr_in];
      end
   end

   assign sum_wide = {1'b0, rdata_ff} + (ACCUM_W+1)'(weight_ff);
   assign sum_sat  = sum_wide[ACCUM_W] ? {ACCUM_W{1'b1}} : sum_wide[ACCUM_W-1:0];

   assign mem_we    = cmd.write_back || cmd.clear_step;
   assign mem_waddr = cmd.clear_step ? clr_ff : idx_ff;
   assign mem_wdata = cmd.clear_step ? '0 : sum_sat;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + IDX_W'(1);
      end
   end

   assign status.clear_last = &clr_ff;
   assign status.rsp_hold   = rsp_valid_ff && rsp_stall;

   // bin centre codes from the packed index
   assign code_r_full = idx_ff >> sh2;
   assign code_g_full = idx_ff >> eff_bpc;
   assign code_r      = code_r_full[MAX_BPC-1:0] & chan_mask;
   assign code_g      = code_g_full[MAX_BPC-1:0] & chan_mask;
   assign code_b      = idx_ff[MAX_BPC-1:0] & chan_mask;
   assign weight_ext  = (ACCUM_W+OUT_W)'(rdata_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_weight_ff <= weight_ext[OUT_W-1:0];
         rsp_red_ff    <= center_of(CENTER_W'(code_r), eff_bpc);
         rsp_green_ff  <= center_of(CENTER_W'(code_g), eff_bpc);
         rsp_blue_ff   <= center_of(CENTER_W'(code_b), eff_bpc);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bin_weight   = rsp_weight_ff;
   assign rsp_center_red   = rsp_red_ff;
   assign rsp_center_green = rsp_green_ff;
   assign rsp_center_blue  = rsp_blue_ff;

endmodule

// ===== hdl/weighted_rgb_histogram_top.sv =====
// top level of the weighted rgb histogram
//
//   port group  direction  handshake         payload
//   req_        in         valid / stall     opcode, colour channels, weight, bin select
//   rsp_        out        valid / stall     bin weight, bin centre colour
//   csr_        in         valid / ready     bits per channel
//
// accumulate reads the bin when accepted and writes the sum back from the accumulate state;
// a read loads the result register from the read state; an unused opcode is accepted and does nothing
// a read waits in the read state while the result register is full and stalled
// clear all writes every bin in turn, one bin written per cycle
// after reset the same sweep runs over every bin with req_stall high
// a pending result does not hold up accumulates and clears
module weighted_rgb_histogram_top import wrh_pkg::*; #(
   parameter int MAX_BITS_PER_CHANNEL = MAX_BPC_DEFAULT,
   parameter int ACCUM_WIDTH          = ACCUM_W_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [BPC_W-1:0]         csr_bits_per_channel,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OPCODE_W-1:0]      req_opcode,
   input  logic signed [CHAN_W-1:0] req_red_value,
   input  logic signed [CHAN_W-1:0] req_green_value,
   input  logic signed [CHAN_W-1:0] req_blue_value,
   input  logic [WEIGHT_W-1:0]      req_sample_weight,
   input  logic [SEL_W-1:0]         req_bin_select,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [OUT_W-1:0]         rsp_bin_weight,
   output logic [CENTER_W-1:0]      rsp_center_red,
   output logic [CENTER_W-1:0]      rsp_center_green,
   output logic [CENTER_W-1:0]      rsp_center_blue
);

   cmd_type    cmd;
   status_type status;

   wrh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   wrh_datapath #(
      .MAX_BPC (MAX_BITS_PER_CHANNEL),
      .ACCUM_W (ACCUM_WIDTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_bits_per_channel (csr_bits_per_channel),
      .req_opcode           (req_opcode),
      .req_red_value        (req_red_value),
      .req_green_value      (req_green_value),
      .req_blue_value       (req_blue_value),
      .req_sample_weight    (req_sample_weight),
      .req_bin_select       (req_bin_select),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_bin_weight       (rsp_bin_weight),
      .rsp_center_red       (rsp_center_red),
      .rsp_center_green     (rsp_center_green),
      .rsp_center_blue      (rsp_center_blue),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

// ===== test/weighted_rgb_histogram_checker.sv =====
// scoreboard for the weighted rgb histogram: tracks bin totals and checks every bin read result
module weighted_rgb_histogram_checker import wrh_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [BPC_W-1:0]         csr_bits_per_channel,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [OPCODE_W-1:0]      req_opcode,
   input  logic signed [CHAN_W-1:0] req_red_value,
   input  logic signed [CHAN_W-1:0] req_green_value,
   input  logic signed [CHAN_W-1:0] req_blue_value,
   input  logic [WEIGHT_W-1:0]      req_sample_weight,
   input  logic [SEL_W-1:0]         req_bin_select,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [OUT_W-1:0]         rsp_bin_weight,
   input  logic [CENTER_W-1:0]      rsp_center_red,
   input  logic [CENTER_W-1:0]      rsp_center_green,
   input  logic [CENTER_W-1:0]      rsp_center_blue,
   output int                       mismatches,
   output int                       reads_outstanding
);

   localparam int BIN_COUNT = 1 << (3 * MAX_BPC_DEFAULT);

   typedef struct packed {
      logic [OUT_W-1:0]    weight;
      logic [CENTER_W-1:0] red;
      logic [CENTER_W-1:0] green;
      logic [CENTER_W-1:0] blue;
   } bin_report_type;

   logic [ACCUM_W_DEFAULT-1:0] bin_totals [BIN_COUNT];
   logic [BPC_W-1:0]           bpc_setting;
   bin_report_type             awaited_reports [$];
   int                         error_count;

   function automatic logic [SEL_W-1:0] channel_code(input logic signed [CHAN_W-1:0] value,
                                                     input int unsigned bpc);
      int level;
      level = int'(value);
      if (level < 0) begin
         level = 0;
      end else if (level > int'(CHANNEL_MAX)) begin
         level = int'(CHANNEL_MAX);
      end
      return SEL_W'(level >> (CLAMP_W - bpc));
   endfunction

   function automatic logic [CENTER_W-1:0] bin_centre(input logic [SEL_W-1:0] code,
                                                      input int unsigned bpc);
      logic [31:0] scaled;
      scaled = (32'(code) * 32'd2 + 32'd1) << (15 - bpc);
      return scaled[CENTER_W-1:0];
   endfunction

   always @(posedge clock) begin
      bin_report_type             seen;
      bin_report_type             want;
      logic [SEL_W-1:0]           idx;
      logic [SEL_W-1:0]           chan_mask;
      logic [ACCUM_W_DEFAULT:0]   sum;
      int unsigned                bpc;
      if (reset) begin
         foreach (bin_totals[i]) bin_totals[i] = '0;
         bpc_setting = BPC_RESET;
         awaited_reports.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.weight = rsp_bin_weight;
            seen.red    = rsp_center_red;
            seen.green  = rsp_center_green;
            seen.blue   = rsp_center_blue;
            if (awaited_reports.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected result transfer: weight %0d centre %h/%h/%h",
                           seen.weight, seen.red, seen.green, seen.blue);
               end
            end else begin
               want = awaited_reports.pop_front();
               if (seen != want) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("bin read mismatch: expected weight %0d centre %h/%h/%h",
                              want.weight, want.red, want.green, want.blue);
                     $display("                   got      weight %0d centre %h/%h/%h",
                              seen.weight, seen.red, seen.green, seen.blue);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            bpc_setting = csr_bits_per_channel;
         end
         if (req_valid && !req_stall) begin
            if (bpc_setting == '0) begin
               bpc = 1;
            end else if (int'(bpc_setting) > MAX_BPC_DEFAULT) begin
               bpc = MAX_BPC_DEFAULT;
            end else begin
               bpc = 32'(bpc_setting);
            end
            chan_mask = SEL_W'((1 << bpc) - 1);
            case (req_opcode)
               OP_ACCUM: begin
                  idx = (channel_code(req_red_value, bpc) << (2 * bpc))
                      | (channel_code(req_green_value, bpc) << bpc)
                      | channel_code(req_blue_value, bpc);
                  sum = {1'b0, bin_totals[idx]} + (ACCUM_W_DEFAULT+1)'(req_sample_weight);
                  bin_totals[idx] = sum[ACCUM_W_DEFAULT] ? '1 : sum[ACCUM_W_DEFAULT-1:0];
               end
               OP_READ: begin
                  idx = req_bin_select & SEL_W'((1 << (3 * bpc)) - 1);
                  want.weight = bin_totals[idx];
                  want.red    = bin_centre((idx >> (2 * bpc)) & chan_mask, bpc);
                  want.green  = bin_centre((idx >> bpc) & chan_mask, bpc);
                  want.blue   = bin_centre(idx & chan_mask, bpc);
                  awaited_reports.push_back(want);
               end
               OP_CLEAR: begin
                  foreach (bin_totals[i]) bin_totals[i] = '0;
               end
               default: begin
               end
            endcase
         end
      end
      mismatches        <= error_count;
      reads_outstanding <= awaited_reports.size();
   end

endmodule

// ===== test/testbench.sv =====
// stimulus, clock, reset and verdict for the weighted rgb histogram
module testbench;
   import wrh_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
   localparam int PHASE_ITEMS  = 54;
   localparam int STALL_LIMIT  = 30000;
   localparam int SWEEP_CYCLES = 4200;
   localparam int PALETTE_SIZE = 4;

   logic                     clock;
   logic                     reset;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [BPC_W-1:0]         csr_bits_per_channel;
   logic                     req_valid;
   logic                     req_stall;
   logic [OPCODE_W-1:0]      req_opcode;
   logic signed [CHAN_W-1:0] req_red_value;
   logic signed [CHAN_W-1:0] req_green_value;
   logic signed [CHAN_W-1:0] req_blue_value;
   logic [WEIGHT_W-1:0]      req_sample_weight;
   logic [SEL_W-1:0]         req_bin_select;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [OUT_W-1:0]         rsp_bin_weight;
   logic [CENTER_W-1:0]      rsp_center_red;
   logic [CENTER_W-1:0]      rsp_center_green;
   logic [CENTER_W-1:0]      rsp_center_blue;

   int                       mismatches;
   int                       reads_outstanding;
   int                       idle_cycles;
   int                       quiet_items;
   int                       accum_count;
   int                       read_count;
   int                       clear_count;
   int                       spare_count;
   int unsigned              bpc_now;
   logic [SEL_W-1:0]         palette [PALETTE_SIZE];

   weighted_rgb_histogram_top dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_bits_per_channel (csr_bits_per_channel),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_red_value        (req_red_value),
      .req_green_value      (req_green_value),
      .req_blue_value       (req_blue_value),
      .req_sample_weight    (req_sample_weight),
      .req_bin_select       (req_bin_select),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_bin_weight       (rsp_bin_weight),
      .rsp_center_red       (rsp_center_red),
      .rsp_center_green     (rsp_center_green),
      .rsp_center_blue      (rsp_center_blue)
   );

   weighted_rgb_histogram_checker check_u (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_bits_per_channel (csr_bits_per_channel),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_opcode           (req_opcode),
      .req_red_value        (req_red_value),
      .req_green_value      (req_green_value),
      .req_blue_value       (req_blue_value),
      .req_sample_weight    (req_sample_weight),
      .req_bin_select       (req_bin_select),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_bin_weight       (rsp_bin_weight),
      .rsp_center_red       (rsp_center_red),
      .rsp_center_green     (rsp_center_green),
      .rsp_center_blue      (rsp_center_blue),
      .mismatches           (mismatches),
      .reads_outstanding    (reads_outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // channel value that lands in the given sub-bin, low bits random
   function automatic logic signed [CHAN_W-1:0] channel_for(input logic [SEL_W-1:0] code,
                                                            input int unsigned bpc);
      if (code == '0 && $urandom_range(0, 3) == 0) begin
         return CHAN_W'(32'd0 - $urandom_range(1, 131072));
      end
      return CHAN_W'((32'(code) << (CLAMP_W - bpc))
                     | $urandom_range(0, (1 << (CLAMP_W - bpc)) - 1));
   endfunction

   function automatic logic [WEIGHT_W-1:0] any_weight();
      if ($urandom_range(0, 9) == 0) return '1;
      return WEIGHT_W'($urandom);
   endfunction

   task automatic send_request(input logic [OPCODE_W-1:0]      op,
                               input logic signed [CHAN_W-1:0] red,
                               input logic signed [CHAN_W-1:0] green,
                               input logic signed [CHAN_W-1:0] blue,
                               input logic [WEIGHT_W-1:0]      weight,
                               input logic [SEL_W-1:0]         select);
      int gap;
      if (quiet_items > 0) begin
         quiet_items--;
         gap = 0;
      end else begin
         gap = gap_len();
         if ($urandom_range(0, 39) == 0) quiet_items = $urandom_range(16, 48);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_red_value     <= red;
      req_green_value   <= green;
      req_blue_value    <= blue;
      req_sample_weight <= weight;
      req_bin_select    <= select;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (op)
         OP_ACCUM: accum_count++;
         OP_READ:  read_count++;
         OP_CLEAR: clear_count++;
         default:  spare_count++;
      endcase
   endtask

   task automatic drain_reads();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reads_outstanding != 0) @(posedge clock);
   endtask

   // a clear sweep may still be running after the last result
   task automatic write_bpc(input logic [BPC_W-1:0] setting);
      drain_reads();
      repeat (SWEEP_CYCLES) @(posedge clock);
      csr_valid            <= 1'b1;
      csr_bits_per_channel <= setting;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (setting == '0) begin
         bpc_now = 1;
      end else if (int'(setting) > MAX_BPC_DEFAULT) begin
         bpc_now = MAX_BPC_DEFAULT;
      end else begin
         bpc_now = setting;
      end
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int run;
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : gap_len();
         repeat (run + 1) @(posedge clock);
         hold = gap_len();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [BPC_W-1:0] bpc_plan [7];
      logic [SEL_W-1:0] entry;
      logic [SEL_W-1:0] chan_mask;
      logic [SEL_W-1:0] bin_mask;
      int               pick;
      int               issued;
      bpc_plan             = '{3'd1, 3'd0, 3'd2, 3'd7, 3'd3, 3'd5, 3'd4};
      reset                <= 1'b1;
      csr_valid            <= 1'b0;
      csr_bits_per_channel <= '0;
      req_valid            <= 1'b0;
      req_opcode           <= OP_ACCUM;
      req_red_value        <= '0;
      req_green_value      <= '0;
      req_blue_value       <= '0;
      req_sample_weight    <= '0;
      req_bin_select       <= '0;
      idle_cycles          = 0;
      quiet_items          = 0;
      bpc_now              = MAX_BPC_DEFAULT;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // four bits per channel after reset
      send_request(OP_READ, 0, 0, 0, 0, 12'h000);
      send_request(OP_ACCUM, 18'h20000, 18'h1FFFF, 18'd65470, 16'hFFFF, 0);
      send_request(OP_ACCUM, 18'h20000, 18'h1FFFF, 18'd65470, 16'h0001, 0);
      send_request(OP_READ, 0, 0, 0, 0, 12'h0FF);
      send_request(OP_ACCUM, 18'd65470, 18'd65471, 18'd65469, 16'h0000, 0);
      send_request(OP_ACCUM, 18'd65535, 18'h10000, 18'h3FFFF, 16'd300, 0);
      send_request(OP_READ, 0, 0, 0, 0, 12'hFF0);
      send_request(OP_READ, 0, 0, 0, 0, 12'hFFF);
      send_request(OP_ACCUM, 0, 0, 0, 16'hFFFF, 0);
      send_request(OP_READ, 0, 0, 0, 0, 12'h000);
      send_request(OP_SPARE, 0, 0, 0, 16'hFFFF, 12'h000);
      send_request(OP_READ, 0, 0, 0, 0, 12'h000);
      send_request(OP_ACCUM, 18'd4096, 18'd8192, 18'd12288, 16'h1234, 0);
      send_request(OP_ACCUM, 18'd4096, 18'd8192, 18'd12288, 16'h00FF, 0);
      send_request(OP_ACCUM, 18'd4100, 18'd8200, 18'd12300, 16'hFF00, 0);
      send_request(OP_READ, 0, 0, 0, 0, 12'h123);
      send_request(OP_CLEAR, 0, 0, 0, 0, 0);
      send_request(OP_READ, 0, 0, 0, 0, 12'h0FF);
      send_request(OP_READ, 0, 0, 0, 0, 12'h123);
      send_request(OP_ACCUM, 0, 0, 0, 16'd5, 0);
      send_request(OP_READ, 0, 0, 0, 0, 12'h000);
      send_request(OP_READ, 0, 0, 0, 0, 12'hFFF);

      foreach (bpc_plan[p]) begin
         write_bpc(bpc_plan[p]);
         chan_mask = SEL_W'((1 << bpc_now) - 1);
         bin_mask  = SEL_W'((1 << (3 * bpc_now)) - 1);
         foreach (palette[k]) palette[k] = SEL_W'($urandom) & bin_mask;
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            pick  = $urandom_range(0, 99);
            entry = palette[$urandom_range(0, PALETTE_SIZE - 1)];
            if (pick < 3) begin
               send_request(OP_CLEAR, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                            WEIGHT_W'($urandom), SEL_W'($urandom));
            end else if (pick < 6) begin
               send_request(OP_SPARE, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                            WEIGHT_W'($urandom), SEL_W'($urandom));
            end else if (pick < 50) begin
               send_request(OP_ACCUM,
                            channel_for((entry >> (2 * bpc_now)) & chan_mask, bpc_now),
                            channel_for((entry >> bpc_now) & chan_mask, bpc_now),
                            channel_for(entry & chan_mask, bpc_now),
                            any_weight(), SEL_W'($urandom));
            end else if (pick < 62) begin
               send_request(OP_ACCUM, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                            any_weight(), SEL_W'($urandom));
            end else if (pick < 90) begin
               // upper select bits beyond the bin count should wrap
               if ($urandom_range(0, 1) == 1) entry = entry | (SEL_W'($urandom) & ~bin_mask);
               send_request(OP_READ, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                            WEIGHT_W'($urandom), entry);
            end else begin
               send_request(OP_READ, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                            WEIGHT_W'($urandom), SEL_W'($urandom));
            end
            if (pick < 3 || pick >= 6) issued++;
            if ($urandom_range(0, 39) == 0) drain_reads();
         end
      end

      drain_reads();
      repeat (50) @(posedge clock);
      $display("run covered %0d accumulates, %0d bin reads, %0d clears, %0d unused opcodes",
               accum_count, read_count, clear_count, spare_count);
      $display("across the reset setting and %0d register writes, out-of-range values included",
               $size(bpc_plan));
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/wrh_pkg.sv
hdl/wrh_ctrl.sv
hdl/wrh_datapath.sv
hdl/weighted_rgb_histogram_top.sv
test/weighted_rgb_histogram_checker.sv
test/testbench.sv
